### hw/rtl/hawkes_pkg.sv
// ----------------------------------------------------------------------------
// hawkes_pkg
// Shared types, constants and tables for the Hawkes log-likelihood core.
// ----------------------------------------------------------------------------
`default_nettype none

package hawkes_pkg;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        REG_BACKGROUND_RATE = 2'd0,
        REG_BRANCHING_RATIO = 2'd1,
        REG_KERNEL_DECAY    = 2'd2,
        REG_END_TIME        = 2'd3
    } cfg_reg_t;

    localparam logic [31:0] MU_RESET    = 32'd65536;
    localparam logic [31:0] N_RESET     = 32'd32768;
    localparam logic [31:0] B_RESET     = 32'd65536;
    localparam logic [31:0] T_RESET     = 32'd6553600;

    localparam logic [32:0] ONE_Q32     = 33'h1_0000_0000;
    localparam logic [31:0] EXP_NEG1    = 32'd1580030169;
    localparam logic [31:0] LN2_Q32     = 32'd2977044472;
    localparam logic [47:0] EXP_CUTOFF  = 48'd1572864;
    localparam logic [3:0]  HORNER_TOP  = 4'd12;
    localparam logic [4:0]  SQ_STEPS    = 5'd16;
    localparam logic [2:0]  NORM_LAST   = 3'd5;

    localparam logic signed [49:0] TOTAL_MAX = 50'sh0_7FFF_FFFF_FFFF;
    localparam logic signed [49:0] TOTAL_MIN = 50'sh3_8000_0000_0000;

    // Datapath operations issued by the controller.
    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_MUL_MUT,
        OP_ADD_MUT,
        OP_MUL_GAPA,
        OP_MUL_GAPT,
        OP_SET_Y,
        OP_EXP_INIT,
        OP_MUL_FT,
        OP_MUL_RCP,
        OP_CORR,
        OP_MUL_TK,
        OP_POST_TK,
        OP_MUL_SE,
        OP_SET_A,
        OP_MUL_NE,
        OP_ADD_NE,
        OP_MUL_NB,
        OP_SET_NB,
        OP_MUL_HI,
        OP_SET_HI,
        OP_MUL_LO,
        OP_SET_LAM,
        OP_LN_NORM,
        OP_LN_MANT,
        OP_MUL_SQ,
        OP_POST_SQ,
        OP_MUL_LN2,
        OP_ADD_LN,
        OP_OUT
    } op_t;

    typedef enum logic [5:0] {
        ST_IDLE,
        ST_FIRST_MUL,
        ST_FIRST_ADD,
        ST_GA_MUL,
        ST_GA_Y,
        ST_EXP_INIT,
        ST_EXP_FT,
        ST_EXP_RCP,
        ST_EXP_CORR,
        ST_EXP_K,
        ST_EXP_KPOST,
        ST_SE_MUL,
        ST_SE_SET,
        ST_GT_MUL,
        ST_GT_Y,
        ST_NE_MUL,
        ST_NE_ADD,
        ST_NB_MUL,
        ST_NB_SET,
        ST_HI_MUL,
        ST_HI_SET,
        ST_LO_MUL,
        ST_LAM_SET,
        ST_LAM_CHK,
        ST_LN_NORM,
        ST_LN_MANT,
        ST_LN_SQ,
        ST_LN_SQPOST,
        ST_LN_MUL,
        ST_LN_ADD,
        ST_FINISH
    } state_t;

    typedef struct packed {
        op_t op;
    } cmd_t;

    typedef struct packed {
        logic first_pending;
        logic y_big;
        logic d_last;
        logic k_zero;
        logic j_last;
        logic cnt_last;
        logic lam_zero;
        logic last_event;
        logic out_free;
    } status_t;

    // floor(2^32 / d) for the Horner divisors; one compare fixes the quotient.
    function automatic logic [32:0] recip(input logic [3:0] d);
        logic [32:0] r;
        case (d)
            4'd1:    r = 33'h1_0000_0000;
            4'd2:    r = 33'd2147483648;
            4'd3:    r = 33'd1431655765;
            4'd4:    r = 33'd1073741824;
            4'd5:    r = 33'd858993459;
            4'd6:    r = 33'd715827882;
            4'd7:    r = 33'd613566756;
            4'd8:    r = 33'd536870912;
            4'd9:    r = 33'd477218588;
            4'd10:   r = 33'd429496729;
            4'd11:   r = 33'd390451572;
            4'd12:   r = 33'd357913941;
            default: r = 33'd0;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

### hw/rtl/hawkes_ctrl.sv
// ----------------------------------------------------------------------------
// hawkes_ctrl
// Sequencer that steps the shared multiplier datapath through one event.
// ----------------------------------------------------------------------------
`default_nettype none

module hawkes_ctrl (
    input  wire                  aclk,
    input  wire                  aresetn,
    input  wire                  s_valid,
    output logic                 s_ready,
    input  hawkes_pkg::status_t  status,
    output hawkes_pkg::cmd_t     cmd
);

    hawkes_pkg::state_t state_reg, state_next;
    logic exp_sel_reg, exp_sel_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= hawkes_pkg::ST_IDLE;
            exp_sel_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            exp_sel_reg <= exp_sel_next;
        end
    end

    always_comb begin
        state_next   = state_reg;
        exp_sel_next = exp_sel_reg;
        case (state_reg)
            hawkes_pkg::ST_IDLE: begin
                if (s_valid) begin
                    state_next = status.first_pending ? hawkes_pkg::ST_FIRST_MUL
                                                      : hawkes_pkg::ST_GA_MUL;
                end
            end
            hawkes_pkg::ST_FIRST_MUL: state_next = hawkes_pkg::ST_FIRST_ADD;
            hawkes_pkg::ST_FIRST_ADD: state_next = hawkes_pkg::ST_GT_MUL;
            hawkes_pkg::ST_GA_MUL:    state_next = hawkes_pkg::ST_GA_Y;
            hawkes_pkg::ST_GA_Y: begin
                state_next   = hawkes_pkg::ST_EXP_INIT;
                exp_sel_next = 1'b0;
            end
            hawkes_pkg::ST_EXP_INIT: begin
                state_next = status.y_big ? hawkes_pkg::ST_EXP_K : hawkes_pkg::ST_EXP_FT;
            end
            hawkes_pkg::ST_EXP_FT:    state_next = hawkes_pkg::ST_EXP_RCP;
            hawkes_pkg::ST_EXP_RCP:   state_next = hawkes_pkg::ST_EXP_CORR;
            hawkes_pkg::ST_EXP_CORR: begin
                state_next = status.d_last ? hawkes_pkg::ST_EXP_K : hawkes_pkg::ST_EXP_FT;
            end
            hawkes_pkg::ST_EXP_K: begin
                if (!status.k_zero) begin
                    state_next = hawkes_pkg::ST_EXP_KPOST;
                end else if (exp_sel_reg) begin
                    state_next = hawkes_pkg::ST_NE_MUL;
                end else begin
                    state_next = hawkes_pkg::ST_SE_MUL;
                end
            end
            hawkes_pkg::ST_EXP_KPOST: state_next = hawkes_pkg::ST_EXP_K;
            hawkes_pkg::ST_SE_MUL:    state_next = hawkes_pkg::ST_SE_SET;
            hawkes_pkg::ST_SE_SET:    state_next = hawkes_pkg::ST_GT_MUL;
            hawkes_pkg::ST_GT_MUL:    state_next = hawkes_pkg::ST_GT_Y;
            hawkes_pkg::ST_GT_Y: begin
                state_next   = hawkes_pkg::ST_EXP_INIT;
                exp_sel_next = 1'b1;
            end
            hawkes_pkg::ST_NE_MUL:    state_next = hawkes_pkg::ST_NE_ADD;
            hawkes_pkg::ST_NE_ADD:    state_next = hawkes_pkg::ST_NB_MUL;
            hawkes_pkg::ST_NB_MUL:    state_next = hawkes_pkg::ST_NB_SET;
            hawkes_pkg::ST_NB_SET:    state_next = hawkes_pkg::ST_HI_MUL;
            hawkes_pkg::ST_HI_MUL:    state_next = hawkes_pkg::ST_HI_SET;
            hawkes_pkg::ST_HI_SET:    state_next = hawkes_pkg::ST_LO_MUL;
            hawkes_pkg::ST_LO_MUL:    state_next = hawkes_pkg::ST_LAM_SET;
            hawkes_pkg::ST_LAM_SET:   state_next = hawkes_pkg::ST_LAM_CHK;
            hawkes_pkg::ST_LAM_CHK: begin
                state_next = status.lam_zero ? hawkes_pkg::ST_FINISH
                                             : hawkes_pkg::ST_LN_NORM;
            end
            hawkes_pkg::ST_LN_NORM: begin
                if (status.j_last) begin
                    state_next = hawkes_pkg::ST_LN_MANT;
                end
            end
            hawkes_pkg::ST_LN_MANT:   state_next = hawkes_pkg::ST_LN_SQ;
            hawkes_pkg::ST_LN_SQ:     state_next = hawkes_pkg::ST_LN_SQPOST;
            hawkes_pkg::ST_LN_SQPOST: begin
                state_next = status.cnt_last ? hawkes_pkg::ST_LN_MUL : hawkes_pkg::ST_LN_SQ;
            end
            hawkes_pkg::ST_LN_MUL:    state_next = hawkes_pkg::ST_LN_ADD;
            hawkes_pkg::ST_LN_ADD:    state_next = hawkes_pkg::ST_FINISH;
            hawkes_pkg::ST_FINISH: begin
                if (!status.last_event || status.out_free) begin
                    state_next = hawkes_pkg::ST_IDLE;
                end
            end
            default: state_next = hawkes_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        s_ready = 1'b0;
        cmd.op  = hawkes_pkg::OP_NONE;
        case (state_reg)
            hawkes_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.op = hawkes_pkg::OP_LOAD;
                end
            end
            hawkes_pkg::ST_FIRST_MUL: cmd.op = hawkes_pkg::OP_MUL_MUT;
            hawkes_pkg::ST_FIRST_ADD: cmd.op = hawkes_pkg::OP_ADD_MUT;
            hawkes_pkg::ST_GA_MUL:    cmd.op = hawkes_pkg::OP_MUL_GAPA;
            hawkes_pkg::ST_GA_Y:      cmd.op = hawkes_pkg::OP_SET_Y;
            hawkes_pkg::ST_EXP_INIT:  cmd.op = hawkes_pkg::OP_EXP_INIT;
            hawkes_pkg::ST_EXP_FT:    cmd.op = hawkes_pkg::OP_MUL_FT;
            hawkes_pkg::ST_EXP_RCP:   cmd.op = hawkes_pkg::OP_MUL_RCP;
            hawkes_pkg::ST_EXP_CORR:  cmd.op = hawkes_pkg::OP_CORR;
            hawkes_pkg::ST_EXP_K: begin
                if (!status.k_zero) begin
                    cmd.op = hawkes_pkg::OP_MUL_TK;
                end
            end
            hawkes_pkg::ST_EXP_KPOST: cmd.op = hawkes_pkg::OP_POST_TK;
            hawkes_pkg::ST_SE_MUL:    cmd.op = hawkes_pkg::OP_MUL_SE;
            hawkes_pkg::ST_SE_SET:    cmd.op = hawkes_pkg::OP_SET_A;
            hawkes_pkg::ST_GT_MUL:    cmd.op = hawkes_pkg::OP_MUL_GAPT;
            hawkes_pkg::ST_GT_Y:      cmd.op = hawkes_pkg::OP_SET_Y;
            hawkes_pkg::ST_NE_MUL:    cmd.op = hawkes_pkg::OP_MUL_NE;
            hawkes_pkg::ST_NE_ADD:    cmd.op = hawkes_pkg::OP_ADD_NE;
            hawkes_pkg::ST_NB_MUL:    cmd.op = hawkes_pkg::OP_MUL_NB;
            hawkes_pkg::ST_NB_SET:    cmd.op = hawkes_pkg::OP_SET_NB;
            hawkes_pkg::ST_HI_MUL:    cmd.op = hawkes_pkg::OP_MUL_HI;
            hawkes_pkg::ST_HI_SET:    cmd.op = hawkes_pkg::OP_SET_HI;
            hawkes_pkg::ST_LO_MUL:    cmd.op = hawkes_pkg::OP_MUL_LO;
            hawkes_pkg::ST_LAM_SET:   cmd.op = hawkes_pkg::OP_SET_LAM;
            hawkes_pkg::ST_LAM_CHK:   cmd.op = hawkes_pkg::OP_NONE;
            hawkes_pkg::ST_LN_NORM:   cmd.op = hawkes_pkg::OP_LN_NORM;
            hawkes_pkg::ST_LN_MANT:   cmd.op = hawkes_pkg::OP_LN_MANT;
            hawkes_pkg::ST_LN_SQ:     cmd.op = hawkes_pkg::OP_MUL_SQ;
            hawkes_pkg::ST_LN_SQPOST: cmd.op = hawkes_pkg::OP_POST_SQ;
            hawkes_pkg::ST_LN_MUL:    cmd.op = hawkes_pkg::OP_MUL_LN2;
            hawkes_pkg::ST_LN_ADD:    cmd.op = hawkes_pkg::OP_ADD_LN;
            hawkes_pkg::ST_FINISH: begin
                if (status.last_event && status.out_free) begin
                    cmd.op = hawkes_pkg::OP_OUT;
                end
            end
            default: cmd.op = hawkes_pkg::OP_NONE;
        endcase
    end

    // An accepted item always starts a pass through the sequence.
    a_accept_leaves_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == hawkes_pkg::ST_IDLE && s_valid) |=> state_reg != hawkes_pkg::ST_IDLE)
        else $error("accepted item did not start processing");

    // A non-final item never waits on the result channel.
    a_nonlast_returns: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == hawkes_pkg::ST_FINISH && !status.last_event)
        |=> state_reg == hawkes_pkg::ST_IDLE)
        else $error("non-final item stalled in finish");

    // The exponential loop exits only toward the consumer that entered it.
    a_exp_return: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == hawkes_pkg::ST_EXP_K && status.k_zero && !exp_sel_reg)
        |=> state_reg == hawkes_pkg::ST_SE_MUL)
        else $error("exponential returned to wrong step");

endmodule

`default_nettype wire

### hw/rtl/hawkes_datapath.sv
// ----------------------------------------------------------------------------
// hawkes_datapath
// Shared 33x33 multiplier, fixed-point exp/log state and the running total.
// ----------------------------------------------------------------------------
`default_nettype none

module hawkes_datapath (
    input  wire                  aclk,
    input  wire                  aresetn,
    input  wire                  cfg_wr_en,
    input  wire  [1:0]           cfg_index,
    input  wire  [31:0]          cfg_wr_data,
    input  wire  [31:0]          s_event_time,
    input  wire                  s_last_event,
    output logic                 m_valid,
    input  wire                  m_ready,
    output logic signed [47:0]   m_log_likelihood,
    output logic                 m_log_of_zero,
    input  hawkes_pkg::cmd_t     cmd,
    output hawkes_pkg::status_t  status
);

    logic [31:0] mu_reg, n_reg, b_reg, tend_reg;
    logic [31:0] t_in_reg, t_in_next;
    logic        last_reg, last_next;
    logic [31:0] prev_reg, prev_next;
    logic [31:0] a_reg, a_next;
    logic signed [47:0] total_reg, total_next;
    logic        first_reg, first_next;
    logic        zero_reg, zero_next;
    logic [47:0] y_reg, y_next;
    logic [31:0] f_reg, f_next;
    logic [32:0] t_reg, t_next;
    logic [3:0]  d_reg, d_next;
    logic [4:0]  k_reg, k_next;
    logic [31:0] x_reg, x_next;
    logic [47:0] nb_reg, nb_next;
    logic [63:0] hi_reg, hi_next;
    logic [63:0] lam_reg, lam_next;
    logic [5:0]  s_reg, s_next;
    logic [2:0]  j_reg, j_next;
    logic [30:0] m_reg, m_next;
    logic [15:0] frac_reg, frac_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic [65:0] prod_reg;
    logic        mul_en;
    logic [32:0] mul_a, mul_b;
    logic signed [47:0] out_ll_reg;
    logic        out_zero_reg, m_valid_reg;

    logic [31:0] gap_a, gap_t;
    logic signed [23:0] l2;
    logic [23:0] l2_mag;
    logic signed [49:0] addend, sum;
    logic        add_en;
    logic [35:0] rem;
    logic [31:0] q_fix;
    logic [33:0] a_prod;
    logic [64:0] lam_sum;
    logic [5:0]  sh;
    logic [55:0] ln_rnd;
    logic [31:0] sq_v;

    assign gap_a = (t_in_reg >= prev_reg) ? (t_in_reg - prev_reg) : 32'd0;
    assign gap_t = (tend_reg >= t_in_reg) ? (tend_reg - t_in_reg) : 32'd0;
    // log2 = (p - 16) + frac / 2^16 with p = 63 - s.
    assign l2     = {8'(8'sd47 - $signed({2'b00, s_reg})), frac_reg};
    assign l2_mag = l2[23] ? 24'(-l2) : 24'(l2);
    assign ln_rnd = prod_reg[55:0] + 56'h8000_0000;
    assign sq_v   = prod_reg[61:30];

    always_comb begin
        mul_en = 1'b1;
        mul_a  = 33'd0;
        mul_b  = 33'd0;
        case (cmd.op)
            hawkes_pkg::OP_MUL_MUT:  begin mul_a = {1'b0, mu_reg}; mul_b = {1'b0, tend_reg}; end
            hawkes_pkg::OP_MUL_GAPA: begin mul_a = {1'b0, b_reg};  mul_b = {1'b0, gap_a};    end
            hawkes_pkg::OP_MUL_GAPT: begin mul_a = {1'b0, b_reg};  mul_b = {1'b0, gap_t};    end
            hawkes_pkg::OP_MUL_FT:   begin mul_a = {1'b0, f_reg};  mul_b = t_reg;            end
            hawkes_pkg::OP_MUL_RCP: begin
                mul_a = {1'b0, prod_reg[63:32]};
                mul_b = hawkes_pkg::recip(d_reg);
            end
            hawkes_pkg::OP_MUL_TK:   begin mul_a = t_reg; mul_b = {1'b0, hawkes_pkg::EXP_NEG1}; end
            hawkes_pkg::OP_MUL_SE:   begin mul_a = {1'b0, a_reg} + 33'd65536; mul_b = t_reg; end
            hawkes_pkg::OP_MUL_NE: begin
                mul_a = {1'b0, n_reg};
                mul_b = hawkes_pkg::ONE_Q32 - t_reg;
            end
            hawkes_pkg::OP_MUL_NB:   begin mul_a = {1'b0, n_reg}; mul_b = {1'b0, b_reg}; end
            hawkes_pkg::OP_MUL_HI:   begin mul_a = {1'b0, nb_reg[47:16]}; mul_b = {1'b0, a_reg}; end
            hawkes_pkg::OP_MUL_LO:   begin mul_a = {17'd0, nb_reg[15:0]}; mul_b = {1'b0, a_reg}; end
            hawkes_pkg::OP_MUL_SQ:   begin mul_a = {2'b00, m_reg}; mul_b = {2'b00, m_reg}; end
            hawkes_pkg::OP_MUL_LN2: begin
                mul_a = {9'd0, l2_mag};
                mul_b = {1'b0, hawkes_pkg::LN2_Q32};
            end
            default: mul_en = 1'b0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (mul_en) begin
            prod_reg <= mul_a * mul_b;
        end
    end

    always_comb begin
        sum = {{2{total_reg[47]}}, total_reg} + addend;
        if (sum > hawkes_pkg::TOTAL_MAX) begin
            sum = hawkes_pkg::TOTAL_MAX;
        end else if (sum < hawkes_pkg::TOTAL_MIN) begin
            sum = hawkes_pkg::TOTAL_MIN;
        end
    end

    always_comb begin
        t_in_next  = t_in_reg;
        last_next  = last_reg;
        prev_next  = prev_reg;
        a_next     = a_reg;
        total_next = total_reg;
        first_next = first_reg;
        zero_next  = zero_reg;
        y_next     = y_reg;
        f_next     = f_reg;
        t_next     = t_reg;
        d_next     = d_reg;
        k_next     = k_reg;
        x_next     = x_reg;
        nb_next    = nb_reg;
        hi_next    = hi_reg;
        lam_next   = lam_reg;
        s_next     = s_reg;
        j_next     = j_reg;
        m_next     = m_reg;
        frac_next  = frac_reg;
        cnt_next   = cnt_reg;
        add_en     = 1'b0;
        addend     = 50'sd0;
        rem        = 36'd0;
        q_fix      = 32'd0;
        a_prod     = prod_reg[65:32];
        lam_sum    = {1'b0, hi_reg} + {33'd0, prod_reg[47:16]} + {33'd0, mu_reg};
        sh         = 6'd1;
        case (cmd.op)
            hawkes_pkg::OP_LOAD: begin
                t_in_next = s_event_time;
                last_next = s_last_event;
            end
            hawkes_pkg::OP_ADD_MUT: begin
                add_en     = 1'b1;
                addend     = -$signed({2'b00, prod_reg[63:16]});
                a_next     = 32'd0;
                first_next = 1'b0;
            end
            hawkes_pkg::OP_MUL_GAPT: prev_next = t_in_reg;
            hawkes_pkg::OP_SET_Y:    y_next = prod_reg[63:16];
            hawkes_pkg::OP_EXP_INIT: begin
                // From 24 decay constants on, the exponential is taken as zero.
                if (y_reg >= hawkes_pkg::EXP_CUTOFF) begin
                    t_next = 33'd0;
                    k_next = 5'd0;
                end else begin
                    k_next = y_reg[20:16];
                    f_next = {y_reg[15:0], 16'd0};
                    t_next = hawkes_pkg::ONE_Q32;
                    d_next = hawkes_pkg::HORNER_TOP;
                end
            end
            hawkes_pkg::OP_MUL_RCP:  x_next = prod_reg[63:32];
            hawkes_pkg::OP_CORR: begin
                // Reciprocal estimate is exact or one low.
                rem   = {4'd0, x_reg} - 36'(prod_reg[63:32] * d_reg);
                q_fix = (rem >= {32'd0, d_reg}) ? prod_reg[63:32] + 32'd1 : prod_reg[63:32];
                t_next = hawkes_pkg::ONE_Q32 - {1'b0, q_fix};
                d_next = d_reg - 4'd1;
            end
            hawkes_pkg::OP_POST_TK: begin
                t_next = prod_reg[64:32];
                k_next = k_reg - 5'd1;
            end
            hawkes_pkg::OP_SET_A: begin
                a_next = (|a_prod[33:32]) ? 32'hFFFF_FFFF : a_prod[31:0];
            end
            hawkes_pkg::OP_ADD_NE: begin
                add_en = 1'b1;
                addend = -$signed({17'd0, prod_reg[64:32]});
            end
            hawkes_pkg::OP_SET_NB:   nb_next = prod_reg[63:16];
            hawkes_pkg::OP_SET_HI:   hi_next = prod_reg[63:0];
            hawkes_pkg::OP_SET_LAM: begin
                lam_next = lam_sum[64] ? 64'hFFFF_FFFF_FFFF_FFFF : lam_sum[63:0];
                if (lam_next == 64'd0) begin
                    zero_next = 1'b1;
                end
                s_next = 6'd0;
                j_next = 3'd0;
            end
            hawkes_pkg::OP_LN_NORM: begin
                case (j_reg)
                    3'd0:    sh = 6'd32;
                    3'd1:    sh = 6'd16;
                    3'd2:    sh = 6'd8;
                    3'd3:    sh = 6'd4;
                    3'd4:    sh = 6'd2;
                    default: sh = 6'd1;
                endcase
                if ((lam_reg >> (7'd64 - {1'b0, sh})) == 64'd0) begin
                    lam_next = lam_reg << sh;
                    s_next   = s_reg + sh;
                end
                j_next = j_reg + 3'd1;
            end
            hawkes_pkg::OP_LN_MANT: begin
                m_next    = lam_reg[63:33];
                frac_next = 16'd0;
                cnt_next  = hawkes_pkg::SQ_STEPS;
            end
            hawkes_pkg::OP_POST_SQ: begin
                m_next    = sq_v[31] ? sq_v[31:1] : sq_v[30:0];
                frac_next = {frac_reg[14:0], sq_v[31]};
                cnt_next  = cnt_reg - 5'd1;
            end
            hawkes_pkg::OP_ADD_LN: begin
                add_en = 1'b1;
                addend = l2[23] ? -$signed({26'd0, ln_rnd[55:32]})
                                : $signed({26'd0, ln_rnd[55:32]});
            end
            hawkes_pkg::OP_OUT: begin
                prev_next  = 32'd0;
                a_next     = 32'd0;
                first_next = 1'b1;
                zero_next  = 1'b0;
            end
            default: ;
        endcase
        if (add_en) begin
            total_next = sum[47:0];
        end
        if (cmd.op == hawkes_pkg::OP_OUT) begin
            total_next = 48'sd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mu_reg      <= hawkes_pkg::MU_RESET;
            n_reg       <= hawkes_pkg::N_RESET;
            b_reg       <= hawkes_pkg::B_RESET;
            tend_reg    <= hawkes_pkg::T_RESET;
            prev_reg    <= 32'd0;
            a_reg       <= 32'd0;
            total_reg   <= 48'sd0;
            first_reg   <= 1'b1;
            zero_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    hawkes_pkg::REG_BACKGROUND_RATE: mu_reg   <= cfg_wr_data;
                    hawkes_pkg::REG_BRANCHING_RATIO: n_reg    <= cfg_wr_data;
                    hawkes_pkg::REG_KERNEL_DECAY:    b_reg    <= cfg_wr_data;
                    hawkes_pkg::REG_END_TIME:        tend_reg <= cfg_wr_data;
                    default: ;
                endcase
            end
            prev_reg  <= prev_next;
            a_reg     <= a_next;
            total_reg <= total_next;
            first_reg <= first_next;
            zero_reg  <= zero_next;
            if (cmd.op == hawkes_pkg::OP_OUT) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        t_in_reg <= t_in_next;
        last_reg <= last_next;
        y_reg    <= y_next;
        f_reg    <= f_next;
        t_reg    <= t_next;
        d_reg    <= d_next;
        k_reg    <= k_next;
        x_reg    <= x_next;
        nb_reg   <= nb_next;
        hi_reg   <= hi_next;
        lam_reg  <= lam_next;
        s_reg    <= s_next;
        j_reg    <= j_next;
        m_reg    <= m_next;
        frac_reg <= frac_next;
        cnt_reg  <= cnt_next;
        if (cmd.op == hawkes_pkg::OP_OUT) begin
            out_ll_reg   <= total_reg;
            out_zero_reg <= zero_reg;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_log_likelihood = out_ll_reg;
    assign m_log_of_zero    = out_zero_reg;

    assign status.first_pending = first_reg;
    assign status.y_big         = (y_reg >= hawkes_pkg::EXP_CUTOFF);
    assign status.d_last        = (d_reg == 4'd1);
    assign status.k_zero        = (k_reg == 5'd0);
    assign status.j_last        = (j_reg == hawkes_pkg::NORM_LAST);
    assign status.cnt_last      = (cnt_reg == 5'd1);
    assign status.lam_zero      = (lam_reg == 64'd0);
    assign status.last_event    = last_reg;
    assign status.out_free      = !m_valid_reg || m_ready;

    // Emitting a result restarts the sequence state.
    a_out_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.op == hawkes_pkg::OP_OUT) |=> (first_reg && total_reg == 48'sd0 && m_valid_reg))
        else $error("result emission did not clear sequence state");

    // Horner steps never run with a zero divisor.
    a_corr_divisor: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.op == hawkes_pkg::OP_CORR) |-> d_reg != 4'd0)
        else $error("Horner step with zero divisor");

endmodule

`default_nettype wire

### hw/rtl/hawkes_exp_log_likelihood_core.sv
// Each event is stepped through the shared multiplier: each exponential runs
// 12 Horner steps plus one multiply by e^-1 per whole decay constant, and the
// logarithm normalizes and then squares the mantissa once per fraction bit. One
// event is in work at a time; a final event waits while the previous result is
// still held. Reset (aresetn, synchronous, active low) restores the configuration
// defaults and clears the sequence state.
// ----------------------------------------------------------------------------
// hawkes_exp_log_likelihood_core
// Hawkes process log-likelihood with an exponential kernel, fixed point.
// ----------------------------------------------------------------------------
`default_nettype none

module hawkes_exp_log_likelihood_core (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire                 cfg_wr_en,
    input  wire  [1:0]          cfg_index,
    input  wire  [31:0]         cfg_wr_data,
    input  wire                 s_valid,
    output logic                s_ready,
    input  wire  [31:0]         s_event_time,
    input  wire                 s_last_event,
    output logic                m_valid,
    input  wire                 m_ready,
    output logic signed [47:0]  m_log_likelihood,
    output logic                m_log_of_zero
);

    hawkes_pkg::cmd_t    cmd;
    hawkes_pkg::status_t status;

    hawkes_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    hawkes_datapath u_datapath (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_index        (cfg_index),
        .cfg_wr_data      (cfg_wr_data),
        .s_event_time     (s_event_time),
        .s_last_event     (s_last_event),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_log_likelihood (m_log_likelihood),
        .m_log_of_zero    (m_log_of_zero),
        .cmd              (cmd),
        .status           (status)
    );

endmodule

`default_nettype wire

### tb/hawkes_ll_checker.sv
// ----------------------------------------------------------------------------
// hawkes_ll_checker
// Watches the configuration port and both item channels of the Hawkes
// log-likelihood core, predicts each sequence total from the accepted events
// and compares every result item with the oldest prediction.
// ----------------------------------------------------------------------------
`default_nettype none

module hawkes_ll_checker (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         cfg_wr_en,
    input  wire  [1:0]  cfg_index,
    input  wire  [31:0] cfg_wr_data,
    input  wire         s_valid,
    input  wire         s_ready,
    input  wire  [31:0] s_event_time,
    input  wire         s_last_event,
    input  wire         m_valid,
    input  wire         m_ready,
    input  wire  [47:0] m_log_likelihood,
    input  wire         m_log_of_zero,
    output int          fail_count,
    output int          totals_pending
);

    typedef struct packed {
        logic [47:0] total;
        logic        zero_flag;
    } ll_result_t;

    localparam longint unsigned Q32_ONE   = 64'h1_0000_0000;
    localparam longint unsigned E_INV     = 64'd1580030169;
    localparam longint unsigned LN2_FRAC  = 64'd2977044472;
    localparam longint          SUM_MAX   = 64'sd140737488355327;
    localparam longint          SUM_MIN   = -64'sd140737488355328;

    logic [31:0] mu, n_ratio, decay, t_end;
    logic [31:0] prev_t, exc_a;
    longint      total;
    logic        first_evt, zero_hit;
    ll_result_t  totals_q[$];

    // e^-y with y in Q16.16; result in Q0.32.
    function automatic longint unsigned exp_decay(input longint unsigned y);
        longint unsigned k, f, t;
        if (y >= (64'd24 << 16)) return 0;
        k = y >> 16;
        f = (y & 64'hFFFF) << 16;
        t = Q32_ONE;
        for (int d = 12; d >= 1; d--) t = Q32_ONE - ((f * t) >> 32) / d;
        for (longint unsigned i = 0; i < k; i++) t = (t * E_INV) >> 32;
        return t;
    endfunction

    // Natural log of a nonzero Q48.16 value, result Q16.16.
    function automatic longint log_q16(input longint unsigned x);
        int p;
        longint unsigned m, mag;
        longint l2;
        logic [31:0] frac;
        p = 63;
        frac = 0;
        while (p > 0 && x[p] == 1'b0) p--;
        m = (p >= 30) ? (x >> (p - 30)) : (x << (30 - p));
        for (int i = 0; i < 16; i++) begin
            m = (m * m) >> 30;
            frac = frac << 1;
            if (m >= (64'd1 << 31)) begin
                m = m >> 1;
                frac[0] = 1'b1;
            end
        end
        l2 = longint'(p - 16) * 65536 + longint'(frac);
        if (l2 >= 0) begin
            mag = (longint'(l2) * LN2_FRAC + (64'd1 << 31)) >> 32;
            return longint'(mag);
        end
        mag = (longint'(-l2) * LN2_FRAC + (64'd1 << 31)) >> 32;
        return -longint'(mag);
    endfunction

    function automatic void accumulate(input longint v);
        longint s;
        s = total + v;
        if (s > SUM_MAX) s = SUM_MAX;
        if (s < SUM_MIN) s = SUM_MIN;
        total = s;
    endfunction

    function automatic void clear_sequence();
        prev_t = 0;
        exc_a = 0;
        total = 0;
        first_evt = 1'b1;
        zero_hit = 1'b0;
    endfunction

    function automatic void predict_event(input logic [31:0] t, input logic last);
        longint unsigned e, s, a, nb, prod, lam;
        logic [31:0] gap;
        ll_result_t r;
        if (first_evt) begin
            exc_a = 0;
            accumulate(-longint'((longint'(mu) * longint'(t_end)) >> 16));
            first_evt = 1'b0;
        end else begin
            // A gap that goes backwards counts as zero.
            gap = (t >= prev_t) ? t - prev_t : 32'd0;
            e = exp_decay((longint'(decay) * longint'(gap)) >> 16);
            s = longint'(exc_a) + 64'd65536;
            a = ((s >> 32) * e) + (((s & 64'hFFFF_FFFF) * e) >> 32);
            exc_a = (a > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : a[31:0];
        end
        prev_t = t;
        gap = (t_end >= t) ? t_end - t : 32'd0;
        e = exp_decay((longint'(decay) * longint'(gap)) >> 16);
        accumulate(-longint'((longint'(n_ratio) * (Q32_ONE - e)) >> 32));
        nb = (longint'(n_ratio) * longint'(decay)) >> 16;
        prod = (nb >> 16) * longint'(exc_a) + (((nb & 64'hFFFF) * longint'(exc_a)) >> 16);
        lam = prod + longint'(mu);
        if (lam < prod) lam = '1;
        if (lam == 0) zero_hit = 1'b1;
        else accumulate(log_q16(lam));
        if (last) begin
            r.total = total[47:0];
            r.zero_flag = zero_hit;
            totals_q.push_back(r);
            clear_sequence();
        end
    endfunction

    always @(posedge aclk) begin
        ll_result_t want;
        int errs;
        errs = 0;
        if (!aresetn) begin
            mu <= hawkes_pkg::MU_RESET;
            n_ratio <= hawkes_pkg::N_RESET;
            decay <= hawkes_pkg::B_RESET;
            t_end <= hawkes_pkg::T_RESET;
            clear_sequence();
            totals_q.delete();
            fail_count <= 0;
            totals_pending <= 0;
        end else begin
            if (m_valid && m_ready) begin
                if (totals_q.size() == 0) begin
                    $error("unexpected result item: log_likelihood %0d", $signed(m_log_likelihood));
                    errs = errs + 1;
                end else begin
                    want = totals_q.pop_front();
                    if (m_log_likelihood !== want.total) begin
                        $error("log_likelihood: expected %0d, got %0d",
                               $signed(want.total), $signed(m_log_likelihood));
                        errs = errs + 1;
                    end
                    if (m_log_of_zero !== want.zero_flag) begin
                        $error("log_of_zero: expected %0b, got %0b",
                               want.zero_flag, m_log_of_zero);
                        errs = errs + 1;
                    end
                end
            end
            if (s_valid && s_ready) predict_event(s_event_time, s_last_event);
            if (cfg_wr_en) begin
                case (hawkes_pkg::cfg_reg_t'(cfg_index))
                    hawkes_pkg::REG_BACKGROUND_RATE: mu <= cfg_wr_data;
                    hawkes_pkg::REG_BRANCHING_RATIO: n_ratio <= cfg_wr_data;
                    hawkes_pkg::REG_KERNEL_DECAY:    decay <= cfg_wr_data;
                    hawkes_pkg::REG_END_TIME:        t_end <= cfg_wr_data;
                    default: ;
                endcase
            end
            fail_count <= fail_count + errs;
            totals_pending <= totals_q.size();
        end
    end

endmodule

`default_nettype wire

### tb/tb_hawkes_exp_log_likelihood_core.sv
// ----------------------------------------------------------------------------
// tb_hawkes_exp_log_likelihood_core
// Drives event sequences under several register settings and handshake
// pressures; a side checker predicts and compares the totals.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_hawkes_exp_log_likelihood_core;

    localparam int CYCLE_LIMIT = 4000000;
    localparam int DRAIN_CYCLES = 400;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [1:0]  cfg_index = '0;
    logic [31:0] cfg_wr_data = '0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [31:0] s_event_time = '0;
    logic        s_last_event = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic signed [47:0] m_log_likelihood;
    logic        m_log_of_zero;
    int          fail_count;
    int          totals_pending;
    int          cycles = 0;
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;

    always #5 aclk = ~aclk;

    hawkes_exp_log_likelihood_core dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wr_data(cfg_wr_data),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_event_time(s_event_time), .s_last_event(s_last_event),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_log_likelihood(m_log_likelihood), .m_log_of_zero(m_log_of_zero)
    );

    hawkes_ll_checker checker_i (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wr_data(cfg_wr_data),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_event_time(s_event_time), .s_last_event(s_last_event),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_log_likelihood(m_log_likelihood), .m_log_of_zero(m_log_of_zero),
        .fail_count(fail_count), .totals_pending(totals_pending)
    );

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    always @(negedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_event(input logic [31:0] t, input logic last);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_event_time <= t;
        s_last_event <= last;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
    endtask

    // Writes happen only with the core idle: all totals back and the last
    // event fully retired.
    task automatic write_regs(input logic [31:0] mu, input logic [31:0] nr,
                              input logic [31:0] b, input logic [31:0] te);
        s_valid <= 1'b0;
        while (totals_pending != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= hawkes_pkg::REG_BACKGROUND_RATE;
        cfg_wr_data <= mu;
        @(negedge aclk);
        cfg_index <= hawkes_pkg::REG_BRANCHING_RATIO;
        cfg_wr_data <= nr;
        @(negedge aclk);
        cfg_index <= hawkes_pkg::REG_KERNEL_DECAY;
        cfg_wr_data <= b;
        @(negedge aclk);
        cfg_index <= hawkes_pkg::REG_END_TIME;
        cfg_wr_data <= te;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 5))
            0: return 32'd0;
            1: return 32'hFFFF_FFFF;
            2: return $urandom_range(0, 32'h3_FFFF);
            3: return $urandom_range(0, 32'h64_0000);
            default: return $urandom;
        endcase
    endfunction

    // Random sequences, mostly well ordered, some with steps back or jumps.
    task automatic random_sequences(input int count);
        logic [31:0] t;
        int len;
        int done;
        done = 0;
        while (done < count) begin
            len = $urandom_range(1, 8);
            t = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 32'h1_0000);
            for (int i = 0; i < len; i++) begin
                case ($urandom_range(0, 9))
                    0: t = t - $urandom_range(1, 32'h2_0000);
                    1: t = $urandom;
                    2: t = t;
                    default: t = t + $urandom_range(0, 32'h4_0000);
                endcase
                send_event(t, i == len - 1);
                done++;
            end
        end
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        send_idle_pct = 11;
        recv_idle_pct = 51;

        // Directed: reset defaults, field extremes, late and backward events.
        send_event(32'd0, 1'b1);
        send_event(32'hFFFF_FFFF, 1'b1);
        send_event(32'd0, 1'b0);
        send_event(32'h1_0000, 1'b0);
        send_event(32'h1_0000, 1'b0);
        send_event(32'h8000, 1'b0);
        send_event(32'h70_0000, 1'b1);
        write_regs(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_event(32'd0, 1'b0);
        send_event(32'd1, 1'b0);
        send_event(32'hFFFF_FFFF, 1'b1);
        // No background and no excitation: every intensity is zero.
        write_regs(32'd0, 32'd0, 32'd0, 32'd0);
        send_event(32'h5555_5555, 1'b0);
        send_event(32'hAAAA_AAAA, 1'b1);
        // Zero background only: the first intensity of each sequence is zero, later ones are not.
        write_regs(32'd0, 32'h1_0000, 32'h1_0000, 32'h10_0000);
        send_event(32'h1_0000, 1'b0);
        send_event(32'h1_8000, 1'b1);
        send_event(32'h2_0000, 1'b1);

        for (int phase = 0; phase < 6; phase++) begin
            if (phase == 2) begin
                send_idle_pct = 51;
                recv_idle_pct = 11;
            end else if (phase == 4) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            if (phase == 5)
                write_regs(hawkes_pkg::MU_RESET, hawkes_pkg::N_RESET,
                           hawkes_pkg::B_RESET, hawkes_pkg::T_RESET);
            else
                write_regs(pick_word(), pick_word(), pick_word(), pick_word());
            random_sequences(260);
        end

        s_valid <= 1'b0;
        while (totals_pending != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

`default_nettype wire

### sim.f
hw/rtl/hawkes_pkg.sv
hw/rtl/hawkes_ctrl.sv
hw/rtl/hawkes_datapath.sv
hw/rtl/hawkes_exp_log_likelihood_core.sv
tb/hawkes_ll_checker.sv
tb/tb_hawkes_exp_log_likelihood_core.sv
